[rtl/assert_macros.svh]
// assertion macros shared by the filter rtl
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RWMF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwmf same-cycle check failed");

// next-cycle implication, checked out of reset
`define RWMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwmf next-cycle check failed");

`endif

[rtl/rwmf_pkg.sv]
// types and constants of the rgb window median filter
// no dependencies
package rwmf_pkg;

    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int KEY_W       = 10;
    localparam int DIM_W       = 13;
    localparam int OUT_W       = 12;
    localparam int CFG_IDX_W   = 8;
    localparam int QUEUE_DEPTH = 8;
    localparam int QCNT_W      = 4;
    localparam int MAX_RESULTS = 4;
    localparam int RCNT_W      = 2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

    // output coordinate ranges of one finished window
    typedef struct packed {
        logic [DIM_W-1:0] a_lo;
        logic [DIM_W-1:0] a_hi;
        logic [DIM_W-1:0] b_lo;
        logic [DIM_W-1:0] b_hi;
        logic             emit;
    } range_t;

    // one queued job: median pixel and the results it feeds
    typedef struct packed {
        logic [PIX_W-1:0] med;
        logic [DIM_W-1:0] a_lo;
        logic [DIM_W-1:0] a_hi;
        logic [DIM_W-1:0] b_lo;
        logic [DIM_W-1:0] b_hi;
    } job_t;

    // pixel rank key: red + green + blue
    function automatic logic [KEY_W-1:0] key_of(input logic [PIX_W-1:0] p);
        key_of = KEY_W'(p[7:0]) + KEY_W'(p[15:8]) + KEY_W'(p[23:16]);
    endfunction

endpackage

[rtl/rwmf_if.sv]
// stream channel interfaces of the rgb window median filter
// depends on rwmf_pkg
interface rwmf_pix_if;
    logic                       valid;
    logic                       ready;
    logic [rwmf_pkg::CH_W-1:0]  pixel_red;
    logic [rwmf_pkg::CH_W-1:0]  pixel_green;
    logic [rwmf_pkg::CH_W-1:0]  pixel_blue;
    modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
    modport sink (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface rwmf_res_if;
    logic                       valid;
    logic                       ready;
    logic [rwmf_pkg::OUT_W-1:0] out_row;
    logic [rwmf_pkg::OUT_W-1:0] out_col;
    logic [rwmf_pkg::CH_W-1:0]  median_red;
    logic [rwmf_pkg::CH_W-1:0]  median_green;
    logic [rwmf_pkg::CH_W-1:0]  median_blue;
    logic                       run_end;
    modport source (output valid, out_row, out_col, median_red, median_green,
                    median_blue, run_end, input ready);
    modport sink (input valid, out_row, out_col, median_red, median_green,
                  median_blue, run_end, output ready);
endinterface

interface rwmf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rwmf_pkg::CFG_IDX_W-1:0] index;
    logic [rwmf_pkg::DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/rwmf_front.sv]
// front end: accepts pixels, keeps line stores and the window, finds output ranges
// depends on rwmf_pkg and rwmf_if
module rwmf_front #(
    parameter int WINDOW     = 3,
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    rwmf_pix_if.sink                                 pix,
    rwmf_cfg_if.sink                                 cfg,
    input  logic                                     room,
    output logic                                     s1_valid,
    output logic                                     win_valid,
    output logic [WINDOW*WINDOW-1:0][rwmf_pkg::PIX_W-1:0] win,
    output logic [WINDOW*WINDOW-1:0]                 win_mask,
    output rwmf_pkg::range_t                         win_rng
);
    localparam int NW     = WINDOW * WINDOW;
    localparam int LS     = (WINDOW > 1) ? WINDOW - 1 : 1;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int SLOT_W = (LS > 1) ? $clog2(LS) : 1;
    localparam int HALF   = WINDOW / 2;
    localparam int DW     = rwmf_pkg::DIM_W;
    localparam int PW     = rwmf_pkg::PIX_W;

    logic [DW-1:0]     width_reg, width_next;
    logic [DW-1:0]     height_reg, height_next;
    logic [DW-1:0]     row_reg, row_next;
    logic [DW-1:0]     col_reg, col_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [DW-1:0]     w_eff, h_eff;
    logic              acc, cfg_hit;
    logic [PW-1:0]     pix_word;

    logic              s1_valid_reg;
    logic [PW-1:0]     s1_pix_reg;
    logic [DW-1:0]     s1_row_reg, s1_col_reg, s1_w_reg, s1_h_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [PW-1:0]     rd_reg [LS];

    logic                       win_valid_reg;
    logic [NW-1:0][PW-1:0]      win_reg, win_next;
    logic [NW-1:0]              mask_reg, mask_next;
    rwmf_pkg::range_t           rng_reg, rng_next;

    // handshakes
    assign acc       = pix.valid && pix.ready;
    assign pix.ready = room;
    assign cfg.ready = 1'b1;
    assign cfg_hit   = cfg.valid && (cfg.index == rwmf_pkg::CFG_IMAGE_WIDTH
                                  || cfg.index == rwmf_pkg::CFG_IMAGE_HEIGHT);
    assign pix_word  = {pix.pixel_blue, pix.pixel_green, pix.pixel_red};

    // effective image size
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = DW'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // config and raster position
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        slot_next   = slot_reg;
        if (cfg_hit)
        begin
            if (cfg.index == rwmf_pkg::CFG_IMAGE_WIDTH)
                width_next = cfg.data;
            else
                height_next = cfg.data;
            row_next  = '0;
            col_next  = '0;
            slot_next = '0;
        end
        else if (acc)
        begin
            if (col_reg + DW'(1) >= w_eff)
            begin
                col_next = '0;
                if (row_reg + DW'(1) >= h_eff)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + DW'(1);
                    slot_next = (32'(slot_reg) + 1 >= LS) ? '0 : slot_reg + SLOT_W'(1);
                end
            end
            else
                col_next = col_reg + DW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rwmf_pkg::WIDTH_RESET;
            height_reg <= rwmf_pkg::HEIGHT_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
            slot_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            slot_reg   <= slot_next;
        end
    end

    // line store banks, read before write at the current column
    for (genvar b = 0; b < LS; b++)
    begin : g_bank
        logic [PW-1:0] mem [MAX_WIDTH];
        always_ff @(posedge clk)
        begin
            if (acc)
            begin
                rd_reg[b] <= mem[col_reg[ADDR_W-1:0]];
                if (32'(slot_reg) == b)
                    mem[col_reg[ADDR_W-1:0]] <= pix_word;
            end
        end
    end

    // stage 1 control and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pix_reg  <= pix_word;
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_w_reg    <= w_eff;
            s1_h_reg    <= h_eff;
            s1_slot_reg <= slot_reg;
        end
    end

    // window shift and new column
    always_comb
    begin
        int bank;
        for (int k = 0; k < WINDOW; k++)
        begin
            for (int j = 0; j < WINDOW - 1; j++)
                win_next[k*WINDOW + j] = win_reg[k*WINDOW + j + 1];
        end
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            bank = 32'(s1_slot_reg) + k;
            if (bank >= LS)
                bank = bank - LS;
            win_next[k*WINDOW + WINDOW - 1] = rd_reg[bank];
        end
        win_next[NW-1] = s1_pix_reg;
    end

    // window mask and output coordinate ranges
    always_comb
    begin
        logic [DW-1:0] wr, wc, sr, sc;
        wr = (32'(s1_h_reg) < WINDOW) ? s1_h_reg : DW'(WINDOW);
        wc = (32'(s1_w_reg) < WINDOW) ? s1_w_reg : DW'(WINDOW);
        for (int k = 0; k < WINDOW; k++)
        begin
            for (int j = 0; j < WINDOW; j++)
                mask_next[k*WINDOW + j] = (k >= WINDOW - 32'(wr)) && (j >= WINDOW - 32'(wc));
        end
        sr = s1_row_reg - (wr - DW'(1));
        sc = s1_col_reg - (wc - DW'(1));
        rng_next.emit = (s1_row_reg >= wr - DW'(1)) && (s1_col_reg >= wc - DW'(1));
        rng_next.a_lo = (sr == '0) ? '0 : sr + DW'(HALF);
        rng_next.a_hi = (sr == s1_h_reg - wr) ? s1_h_reg - DW'(1) : sr + DW'(HALF);
        rng_next.b_lo = (sc == '0) ? '0 : sc + DW'(HALF);
        rng_next.b_hi = (sc == s1_w_reg - wc) ? s1_w_reg - DW'(1) : sc + DW'(HALF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            win_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mask_reg <= mask_next;
            rng_reg  <= rng_next;
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign win_valid = win_valid_reg;
    assign win       = win_reg;
    assign win_mask  = mask_reg;
    assign win_rng   = rng_reg;
endmodule

[rtl/rwmf_median.sv]
// rank network: ranks window pixels by key and picks the middle one
// depends on rwmf_pkg
module rwmf_median #(
    parameter int WINDOW = 3
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          win_valid,
    input  logic [WINDOW*WINDOW-1:0][rwmf_pkg::PIX_W-1:0] win,
    input  logic [WINDOW*WINDOW-1:0]                      win_mask,
    input  rwmf_pkg::range_t                              win_rng,
    output logic                                          rank_valid,
    output logic                                          push,
    output rwmf_pkg::job_t                                job
);
    localparam int NW   = WINDOW * WINDOW;
    localparam int RK_W = $clog2(NW + 1);
    localparam int PW   = rwmf_pkg::PIX_W;

    logic [NW-1:0][RK_W-1:0] rank_next, rank_reg;
    logic [NW-1:0][PW-1:0]   win_reg;
    logic [NW-1:0]           mask_reg;
    rwmf_pkg::range_t        rng_reg;
    logic                    valid_reg;
    logic [PW-1:0]           med;

    // pairwise compare, descending key, earlier position wins ties
    always_comb
    begin
        logic [rwmf_pkg::KEY_W-1:0] ki, kj;
        for (int i = 0; i < NW; i++)
        begin
            rank_next[i] = '0;
            ki = rwmf_pkg::key_of(win[i]);
            for (int j = 0; j < NW; j++)
            begin
                kj = rwmf_pkg::key_of(win[j]);
                if (win_mask[j] && (kj > ki || (kj == ki && j < i)))
                    rank_next[i] = rank_next[i] + RK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= win_valid;
    end

    always_ff @(posedge clk)
    begin
        if (win_valid)
        begin
            rank_reg <= rank_next;
            win_reg  <= win;
            mask_reg <= win_mask;
            rng_reg  <= win_rng;
        end
    end

    // pick the pixel whose rank is n/2
    always_comb
    begin
        logic [RK_W-1:0] mid;
        mid = RK_W'($countones(mask_reg)) >> 1;
        med = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (mask_reg[i] && rank_reg[i] == mid)
                med = med | win_reg[i];
        end
    end

    assign rank_valid = valid_reg;
    assign push       = valid_reg && rng_reg.emit;
    assign job.med    = med;
    assign job.a_lo   = rng_reg.a_lo;
    assign job.a_hi   = rng_reg.a_hi;
    assign job.b_lo   = rng_reg.b_lo;
    assign job.b_hi   = rng_reg.b_hi;
endmodule

[rtl/rwmf_queue.sv]
// job queue between the rank network and the result sequencer
// depends on rwmf_pkg
module rwmf_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  rwmf_pkg::job_t              push_job,
    input  logic                        pop,
    output rwmf_pkg::job_t              head,
    output logic                        empty,
    output logic [rwmf_pkg::QCNT_W-1:0] count
);
    localparam int AW = $clog2(rwmf_pkg::QUEUE_DEPTH);

    rwmf_pkg::job_t              slots [rwmf_pkg::QUEUE_DEPTH];
    logic [AW-1:0]               wr_ptr_reg, rd_ptr_reg;
    logic [rwmf_pkg::QCNT_W-1:0] count_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + rwmf_pkg::QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - rwmf_pkg::QCNT_W'(1);
        end
    end

    assign head  = slots[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;
endmodule

[rtl/rwmf_back.sv]
// result sequencer: walks each job's coordinates into the output register
// depends on rwmf_pkg and rwmf_if
module rwmf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rwmf_pkg::job_t      head,
    input  logic                empty,
    output logic                pop,
    output logic [rwmf_pkg::RCNT_W-1:0] rcnt,
    rwmf_res_if.source          res
);
    localparam int DW = rwmf_pkg::DIM_W;

    logic [DW-1:0]                 da_reg, da_next, db_reg, db_next;
    logic [rwmf_pkg::RCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]                 a_cur, b_cur;
    logic                          load, last;
    logic                          out_valid_reg;
    logic [rwmf_pkg::OUT_W-1:0]    row_reg, col_reg;
    logic [rwmf_pkg::PIX_W-1:0]    med_reg;
    logic                          end_reg;

    // current coordinate and end of job
    assign a_cur = head.a_lo + da_reg;
    assign b_cur = head.b_lo + db_reg;
    assign load  = !empty && (!out_valid_reg || res.ready);
    assign last  = (32'(cnt_reg) == rwmf_pkg::MAX_RESULTS - 1)
                || (a_cur == head.a_hi && b_cur == head.b_hi);
    assign pop   = load && last;

    // iterator advance
    always_comb
    begin
        da_next  = da_reg;
        db_next  = db_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            if (last)
            begin
                da_next  = '0;
                db_next  = '0;
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + rwmf_pkg::RCNT_W'(1);
                if (b_cur == head.b_hi)
                begin
                    db_next = '0;
                    da_next = da_reg + DW'(1);
                end
                else
                    db_next = db_reg + DW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            da_reg        <= '0;
            db_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            da_reg  <= da_next;
            db_reg  <= db_next;
            cnt_reg <= cnt_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= a_cur[rwmf_pkg::OUT_W-1:0];
            col_reg <= b_cur[rwmf_pkg::OUT_W-1:0];
            med_reg <= head.med;
            end_reg <= last;
        end
    end

    assign rcnt             = cnt_reg;
    assign res.valid        = out_valid_reg;
    assign res.out_row      = row_reg;
    assign res.out_col      = col_reg;
    assign res.median_red   = med_reg[7:0];
    assign res.median_green = med_reg[15:8];
    assign res.median_blue  = med_reg[23:16];
    assign res.run_end      = end_reg;
endmodule

[rtl/rgb_window_median_filter_top.sv]
// WINDOW x WINDOW median filter over an RGB raster stream
// ranks each window by red+green+blue, descending, ties by window position
// channels: pix (pixel in), res (filtered pixel out with row/col), cfg (registers)
// cfg index 0 is image_width, 1 is image_height; any known write restarts the frame;
// writes are taken at once and belong only to idle periods
// throughput: one pixel per cycle while pix ready is high, bounded by the single
// line store port per bank; a pixel that finishes k windows yields k results
// (up to 4), one per cycle while res is ready; a result passes through the stage 1,
// window, rank, queue and output registers; a job queue of 8 entries sits between
// ranking and output; pix ready drops once queued plus in-flight jobs would fill
// it, so a stalled receiver backs up to the input without loss
// reset clears counters, window and queue and loads 640 x 480; the line store
// is not cleared, rows not yet written feed no result
// depends on rwmf_pkg, rwmf_if, rwmf_front, rwmf_median, rwmf_queue, rwmf_back
`include "assert_macros.svh"
module rgb_window_median_filter_top #(
    parameter int WINDOW     = 3,
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    rwmf_pix_if.sink    pix,
    rwmf_cfg_if.sink    cfg,
    rwmf_res_if.source  res
);
    localparam int NW = WINDOW * WINDOW;

    logic                                s1_valid, win_valid, rank_valid;
    logic [NW-1:0][rwmf_pkg::PIX_W-1:0]  win;
    logic [NW-1:0]                       win_mask;
    rwmf_pkg::range_t                    win_rng;
    logic                                push, pop, empty, room;
    rwmf_pkg::job_t                      job, head;
    logic [rwmf_pkg::QCNT_W-1:0]         count;
    logic [rwmf_pkg::RCNT_W-1:0]         rcnt;
    logic [rwmf_pkg::QCNT_W:0]           committed;

    // queue credit: queued jobs plus those still in the pipeline
    assign committed = (rwmf_pkg::QCNT_W+1)'(count) + (rwmf_pkg::QCNT_W+1)'(s1_valid)
                     + (rwmf_pkg::QCNT_W+1)'(win_valid) + (rwmf_pkg::QCNT_W+1)'(rank_valid);
    assign room      = 32'(committed) < rwmf_pkg::QUEUE_DEPTH;

    rwmf_front #(
        .WINDOW     (WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .cfg       (cfg),
        .room      (room),
        .s1_valid  (s1_valid),
        .win_valid (win_valid),
        .win       (win),
        .win_mask  (win_mask),
        .win_rng   (win_rng)
    );

    rwmf_median #(
        .WINDOW (WINDOW)
    ) u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .win_valid  (win_valid),
        .win        (win),
        .win_mask   (win_mask),
        .win_rng    (win_rng),
        .rank_valid (rank_valid),
        .push       (push),
        .job        (job)
    );

    rwmf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .count    (count)
    );

    rwmf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .rcnt  (rcnt),
        .res   (res)
    );

    // checks
    `RWMF_ASSERT_NOW(a_no_overflow, push && !pop, 32'(count) < rwmf_pkg::QUEUE_DEPTH)
    `RWMF_ASSERT_NOW(a_pop_has_job, pop, !empty)
    `RWMF_ASSERT_NOW(a_partial_job_held, rcnt != '0, !empty)
    `RWMF_ASSERT_NEXT(a_idle_quiet, !res.valid && empty, !res.valid)
endmodule
